### rtl/core/dcas_pkg.sv
package dcas_pkg;

	localparam int CFG_W   = 16;
	localparam int TIMER_W = 16;
	localparam int IDX_W   = 3;

	localparam logic [TIMER_W-1:0] TMR_MAX = {TIMER_W{1'b1}};

	// event codes
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_STATUS = 2'd1;
	localparam logic [1:0] CMD_ACK    = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PLAN_DELAY    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PLAN_TIMEOUT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ABORT_DELAY   = 3'd2;
	localparam logic [IDX_W-1:0] REG_ABORT_TIMEOUT = 3'd3;

	localparam logic [CFG_W-1:0] PLAN_DELAY_RST    = 16'd120;
	localparam logic [CFG_W-1:0] PLAN_TIMEOUT_RST  = 16'd10;
	localparam logic [CFG_W-1:0] ABORT_DELAY_RST   = 16'd300;
	localparam logic [CFG_W-1:0] ABORT_TIMEOUT_RST = 16'd10;

	// numeric state codes as seen on seq_state
	localparam logic [3:0] CODE_BEGIN       = 4'd0;
	localparam logic [3:0] CODE_MODEM_WAIT  = 4'd1;
	localparam logic [3:0] CODE_PLAN        = 4'd2;
	localparam logic [3:0] CODE_PLAN_DELAY  = 4'd3;
	localparam logic [3:0] CODE_PLAN_SEND   = 4'd4;
	localparam logic [3:0] CODE_PLAN_WAIT   = 4'd5;
	localparam logic [3:0] CODE_PLAN_TOUT   = 4'd6;
	localparam logic [3:0] CODE_ABORT_BEGIN = 4'd7;
	localparam logic [3:0] CODE_ABORT_DELAY = 4'd8;
	localparam logic [3:0] CODE_ABORT_SEND  = 4'd9;
	localparam logic [3:0] CODE_ABORT_WAIT  = 4'd10;
	localparam logic [3:0] CODE_ABORT_TOUT  = 4'd11;
	localparam logic [3:0] CODE_IDLE        = 4'd12;

	typedef enum logic [12:0] {
		ST_BEGIN       = 13'b0000000000001,
		ST_MODEM_WAIT  = 13'b0000000000010,
		ST_PLAN        = 13'b0000000000100,
		ST_PLAN_DELAY  = 13'b0000000001000,
		ST_PLAN_SEND   = 13'b0000000010000,
		ST_PLAN_WAIT   = 13'b0000000100000,
		ST_PLAN_TOUT   = 13'b0000001000000,
		ST_ABORT_BEGIN = 13'b0000010000000,
		ST_ABORT_DELAY = 13'b0000100000000,
		ST_ABORT_SEND  = 13'b0001000000000,
		ST_ABORT_WAIT  = 13'b0010000000000,
		ST_ABORT_TOUT  = 13'b0100000000000,
		ST_IDLE        = 13'b1000000000000
	} phase_t;

	function automatic logic [3:0] phase_code(phase_t p);
		logic [3:0] c;
		case (p)
			ST_BEGIN:       c = CODE_BEGIN;
			ST_MODEM_WAIT:  c = CODE_MODEM_WAIT;
			ST_PLAN:        c = CODE_PLAN;
			ST_PLAN_DELAY:  c = CODE_PLAN_DELAY;
			ST_PLAN_SEND:   c = CODE_PLAN_SEND;
			ST_PLAN_WAIT:   c = CODE_PLAN_WAIT;
			ST_PLAN_TOUT:   c = CODE_PLAN_TOUT;
			ST_ABORT_BEGIN: c = CODE_ABORT_BEGIN;
			ST_ABORT_DELAY: c = CODE_ABORT_DELAY;
			ST_ABORT_SEND:  c = CODE_ABORT_SEND;
			ST_ABORT_WAIT:  c = CODE_ABORT_WAIT;
			ST_ABORT_TOUT:  c = CODE_ABORT_TOUT;
			default:        c = CODE_IDLE;
		endcase
		return c;
	endfunction

	// clamp a register value to the timer range
	function automatic logic [TIMER_W-1:0] timer_load(logic [CFG_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w > 32'(TMR_MAX))
			return TMR_MAX;
		return TIMER_W'(w);
	endfunction

endpackage

### rtl/core/delayed_command_ack_sequencer_top.sv
// channel   direction  signals
// in        in         in_valid/in_ready, cmd, from_modem, modem_online, from_target
// out       out        out_valid/out_ready, seq_state, send_plan, send_abort
// cfg       in         cfg_valid/cfg_ready, cfg_index, cfg_data
//
// One event per cycle while the output is not stalled: an event is captured
// in the input register, then its state step lands in the output register.
// arst_n clears the sequence, flags, timer and registers to their defaults.
// A stalled output holds the input register; in_ready drops only when both
// registers are full. cfg_ready is always high.
module delayed_command_ack_sequencer_top import dcas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  logic             from_modem,
	input  logic             modem_online,
	input  logic             from_target,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       seq_state,
	output logic             send_plan,
	output logic             send_abort,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] plan_delay_q, plan_timeout_q, abort_delay_q, abort_timeout_q;

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic       from_modem_s1, modem_online_s1, from_target_s1;

	phase_t             phase_q, phase_n;
	logic               modem_ready_q, modem_ready_n;
	logic               plan_acked_q, plan_acked_n;
	logic               abort_acked_q, abort_acked_n;
	logic [TIMER_W-1:0] elapsed_q, elapsed_n;
	logic [TIMER_W-1:0] limit_q, limit_n;
	logic               plan_p, abort_p, expired;

	logic       out_valid_q, send_plan_q, send_abort_q;
	logic [3:0] seq_state_q;

	logic advance, step;

	assign advance   = !out_valid_q || out_ready;
	assign step      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid  = out_valid_q;
	assign seq_state  = seq_state_q;
	assign send_plan  = send_plan_q;
	assign send_abort = send_abort_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_delay_q    <= PLAN_DELAY_RST;
			plan_timeout_q  <= PLAN_TIMEOUT_RST;
			abort_delay_q   <= ABORT_DELAY_RST;
			abort_timeout_q <= ABORT_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PLAN_DELAY:    plan_delay_q    <= cfg_data;
				REG_PLAN_TIMEOUT:  plan_timeout_q  <= cfg_data;
				REG_ABORT_DELAY:   abort_delay_q   <= cfg_data;
				REG_ABORT_TIMEOUT: abort_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1          <= cmd;
			from_modem_s1   <= from_modem;
			modem_online_s1 <= modem_online;
			from_target_s1  <= from_target;
		end
	end

	// event effect, then one sequence step
	always_comb begin
		modem_ready_n = modem_ready_q;
		plan_acked_n  = plan_acked_q;
		abort_acked_n = abort_acked_q;
		elapsed_n     = elapsed_q;
		limit_n       = limit_q;
		phase_n       = phase_q;
		plan_p        = 1'b0;
		abort_p       = 1'b0;

		case (cmd_s1)
			CMD_TICK: begin
				if (elapsed_q != TMR_MAX)
					elapsed_n = elapsed_q + 1'b1;
			end
			CMD_STATUS: begin
				if (from_modem_s1)
					modem_ready_n = modem_online_s1;
			end
			CMD_ACK: begin
				if (from_target_s1) begin
					if (phase_q == ST_ABORT_WAIT)
						abort_acked_n = 1'b1;
					else if (phase_q == ST_PLAN_WAIT)
						plan_acked_n = 1'b1;
				end
			end
			default: ;
		endcase

		expired = elapsed_n >= limit_q;

		case (phase_q)
			ST_BEGIN: phase_n = ST_MODEM_WAIT;
			ST_MODEM_WAIT: begin
				if (modem_ready_n)
					phase_n = ST_PLAN;
			end
			ST_PLAN: begin
				elapsed_n = '0;
				limit_n   = timer_load(plan_delay_q);
				phase_n   = ST_PLAN_DELAY;
			end
			ST_PLAN_DELAY: begin
				if (expired)
					phase_n = ST_PLAN_SEND;
			end
			ST_PLAN_SEND: begin
				plan_p    = 1'b1;
				elapsed_n = '0;
				limit_n   = timer_load(plan_timeout_q);
				phase_n   = ST_PLAN_WAIT;
			end
			ST_PLAN_WAIT: begin
				if (plan_acked_n)
					phase_n = ST_ABORT_BEGIN;
				else if (expired)
					phase_n = ST_PLAN_TOUT;
			end
			ST_PLAN_TOUT: phase_n = ST_BEGIN;
			ST_ABORT_BEGIN: begin
				elapsed_n = '0;
				limit_n   = timer_load(abort_delay_q);
				phase_n   = ST_ABORT_DELAY;
			end
			ST_ABORT_DELAY: begin
				if (expired)
					phase_n = ST_ABORT_SEND;
			end
			ST_ABORT_SEND: begin
				abort_p   = 1'b1;
				elapsed_n = '0;
				limit_n   = timer_load(abort_timeout_q);
				phase_n   = ST_ABORT_WAIT;
			end
			ST_ABORT_WAIT: begin
				// timeout wins over a same-step ack
				if (expired)
					phase_n = ST_ABORT_TOUT;
				else if (abort_acked_n)
					phase_n = ST_IDLE;
			end
			ST_ABORT_TOUT: phase_n = ST_ABORT_SEND;
			default: phase_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ST_BEGIN;
			modem_ready_q <= 1'b0;
			plan_acked_q  <= 1'b0;
			abort_acked_q <= 1'b0;
			elapsed_q     <= '0;
			limit_q       <= '0;
		end else if (step) begin
			phase_q       <= phase_n;
			modem_ready_q <= modem_ready_n;
			plan_acked_q  <= plan_acked_n;
			abort_acked_q <= abort_acked_n;
			elapsed_q     <= elapsed_n;
			limit_q       <= limit_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			seq_state_q  <= phase_code(phase_n);
			send_plan_q  <= plan_p;
			send_abort_q <= abort_p;
		end
	end

	a_plan_pulse_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && send_plan) |-> (seq_state == CODE_PLAN_WAIT))
		else $error("send_plan outside plan wait");

	a_abort_pulse_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && send_abort) |-> (seq_state == CODE_ABORT_WAIT))
		else $error("send_abort outside abort wait");

	a_idle_final: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ST_IDLE) |=> (phase_q == ST_IDLE))
		else $error("left idle state");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline stalled");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1) |=> $stable(phase_q))
		else $error("sequence stepped without an event");

endmodule
